### sv/lcd_window_pixel_streamer_top_defines.svh
// Assertion macros shared by the streamer's RTL.
`ifndef LCD_WINDOW_PIXEL_STREAMER_TOP_DEFINES_SVH
`define LCD_WINDOW_PIXEL_STREAMER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LWPS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LWPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/lwps_pkg.sv
// Shared types and constants of the LCD window pixel streamer.
package lwps_pkg;

	localparam int unsigned MAX_DIM_DEF = 1024;

	localparam int unsigned COORD_W = 10;
	localparam int unsigned DIM_W   = 11;
	localparam int unsigned CFG_W   = 11;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned CNT_W   = 21;
	localparam int unsigned REG_IDX_W = 1;

	localparam logic [DIM_W-1:0] PANEL_WIDTH_RST  = 11'd240;
	localparam logic [DIM_W-1:0] PANEL_HEIGHT_RST = 11'd320;

	// Request codes
	localparam logic [1:0] REQ_REGION = 2'd0;
	localparam logic [1:0] REQ_FRAME  = 2'd1;
	localparam logic [1:0] REQ_PIXEL  = 2'd2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_PANEL_WIDTH  = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_PANEL_HEIGHT = 1'd1;

	// Panel commands
	localparam logic [7:0] CMD_CASET = 8'h2a;
	localparam logic [7:0] CMD_RASET = 8'h2b;
	localparam logic [7:0] CMD_RAMWR = 8'h2c;

	// Job queue between front and back
	localparam int unsigned JOBQ_AW    = 2;
	localparam int unsigned JOBQ_DEPTH = 1 << JOBQ_AW;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [COORD_W-1:0] region_x;
		logic [COORD_W-1:0] region_y;
		logic [DIM_W-1:0]   region_w;
		logic [DIM_W-1:0]   region_h;
		logic [31:0]        pixel_word;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_command;
		logic       frame_end;
		logic       run_last;
	} res_t;

	// One unit of back-end work: a window header or one packed pixel.
	// For a pixel, x0 holds the RGB565 value.
	typedef struct packed {
		logic              is_win;
		logic              frame_end;
		logic [ADDR_W-1:0] x0;
		logic [ADDR_W-1:0] x1;
		logic [ADDR_W-1:0] y0;
		logic [ADDR_W-1:0] y1;
	} job_t;

endpackage

### sv/lwps_front.sv
// Front end: configuration, request decode, pixel count and job build.
module lwps_front #(
	parameter int unsigned MAX_DIM = lwps_pkg::MAX_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  lwps_pkg::req_t                  item,
	input  logic                            wr_en,
	input  logic [lwps_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [lwps_pkg::CFG_W-1:0]      wr_data,
	input  logic                            job_full,
	output logic                            job_push,
	output lwps_pkg::job_t                  job
);
	import lwps_pkg::*;

	localparam int unsigned PROD_W = 2 * DIM_W;
	localparam logic [31:0] MAX_DIM_L = 32'(MAX_DIM);
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	logic [DIM_W-1:0]   panel_w_q, panel_h_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               accept, is_start, is_pixel, pix_ok;
	logic [COORD_W-1:0] sx, sy;
	logic [DIM_W-1:0]   sw, sh, cw, ch;
	logic [PROD_W-1:0]  prod;
	logic [CNT_W-1:0]   n_pix;
	logic [15:0]        rgb;

	assign accept = push & ~job_full;
	assign pix_ok = (cnt_q != '0);

	always_comb begin
		is_start = 1'b0;
		is_pixel = 1'b0;
		sx = '0;
		sy = '0;
		sw = panel_w_q;
		sh = panel_h_q;
		case (item.req_type)
			REQ_REGION: begin
				is_start = 1'b1;
				sx = item.region_x;
				sy = item.region_y;
				sw = item.region_w;
				sh = item.region_h;
			end
			REQ_FRAME: begin
				is_start = 1'b1;
			end
			REQ_PIXEL: begin
				is_pixel = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Clamp each side, then saturate the area to the counter range
	assign cw = ({{(32-DIM_W){1'b0}}, sw} > MAX_DIM_L) ? MAX_DIM_L[DIM_W-1:0] : sw;
	assign ch = ({{(32-DIM_W){1'b0}}, sh} > MAX_DIM_L) ? MAX_DIM_L[DIM_W-1:0] : sh;
	assign prod = PROD_W'(cw) * PROD_W'(ch);
	assign n_pix = (prod > PROD_W'(CNT_MAX)) ? CNT_MAX : prod[CNT_W-1:0];

	assign rgb = {item.pixel_word[23:19], item.pixel_word[15:10], item.pixel_word[7:3]};

	always_comb begin
		job.is_win    = is_start;
		job.frame_end = 1'b0;
		job.x0 = '0;
		job.x1 = '0;
		job.y0 = '0;
		job.y1 = '0;
		if (is_start) begin
			job.x0 = ADDR_W'(sx);
			job.y0 = ADDR_W'(sy);
			job.x1 = ADDR_W'(sx) + ADDR_W'(sw) - ADDR_W'(1);
			job.y1 = ADDR_W'(sy) + ADDR_W'(sh) - ADDR_W'(1);
		end else begin
			job.x0 = rgb;
			job.frame_end = (cnt_q == CNT_W'(1));
		end
	end

	// Drop stray pixels and unused codes
	assign job_push = accept & (is_start | (is_pixel & pix_ok));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_w_q <= PANEL_WIDTH_RST;
			panel_h_q <= PANEL_HEIGHT_RST;
			cnt_q     <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_PANEL_WIDTH:  panel_w_q <= wr_data;
					REG_PANEL_HEIGHT: panel_h_q <= wr_data;
					default: begin
					end
				endcase
			end
			if (accept && is_start) begin
				cnt_q <= n_pix;
			end else if (accept && is_pixel && pix_ok) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

### sv/lwps_job_q.sv
// Short job queue between front and back end.
module lwps_job_q (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  lwps_pkg::job_t  wr_job,
	output logic            full,
	input  logic            rd,
	output lwps_pkg::job_t  head,
	output logic            empty
);
	import lwps_pkg::*;

	job_t               mem_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [JOBQ_AW:0]   cnt_q;
	logic               do_wr, do_rd;

	assign full  = (cnt_q == (JOBQ_AW+1)'(JOBQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];
	assign do_wr = wr & ~full;
	assign do_rd = rd & ~empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + JOBQ_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + JOBQ_AW'(1);
			end
			cnt_q <= cnt_q + (JOBQ_AW+1)'(do_wr) - (JOBQ_AW+1)'(do_rd);
		end
	end

endmodule

### sv/lwps_back.sv
// Back end: byte sequencer and two-entry result queue.
module lwps_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_empty,
	input  lwps_pkg::job_t  job_head,
	output logic            job_pop,
	output logic            empty,
	input  logic            pop,
	output lwps_pkg::res_t  result
);
	import lwps_pkg::*;

	localparam logic [3:0] SLOT_CASET  = 4'd0;
	localparam logic [3:0] SLOT_X0_HI  = 4'd1;
	localparam logic [3:0] SLOT_X0_LO  = 4'd2;
	localparam logic [3:0] SLOT_X1_HI  = 4'd3;
	localparam logic [3:0] SLOT_X1_LO  = 4'd4;
	localparam logic [3:0] SLOT_RASET  = 4'd5;
	localparam logic [3:0] SLOT_Y0_HI  = 4'd6;
	localparam logic [3:0] SLOT_Y0_LO  = 4'd7;
	localparam logic [3:0] SLOT_Y1_HI  = 4'd8;
	localparam logic [3:0] SLOT_Y1_LO  = 4'd9;
	localparam logic [3:0] SLOT_RAMWR  = 4'd10;
	localparam logic [3:0] SLOT_PIX_HI = 4'd0;
	localparam logic [3:0] SLOT_PIX_LO = 4'd1;

	logic       busy_q;
	logic [3:0] idx_q;
	job_t       cur_q;

	res_t       oq_q [2];
	logic       owr_q, ord_q;
	logic [1:0] ocnt_q;

	logic       space, emit, last, pop_ok;
	res_t       beat;

	assign space  = (ocnt_q != 2'd2);
	assign emit   = busy_q & space;
	assign last   = cur_q.is_win ? (idx_q == SLOT_RAMWR) : (idx_q == SLOT_PIX_LO);
	assign job_pop = ~job_empty & (~busy_q | (emit & last));
	assign pop_ok = pop & (ocnt_q != 2'd0);

	always_comb begin
		beat.out_byte   = '0;
		beat.is_command = 1'b0;
		beat.frame_end  = 1'b0;
		beat.run_last   = last;
		if (cur_q.is_win) begin
			case (idx_q)
				SLOT_CASET: begin
					beat.out_byte = CMD_CASET;
					beat.is_command = 1'b1;
				end
				SLOT_X0_HI: beat.out_byte = cur_q.x0[15:8];
				SLOT_X0_LO: beat.out_byte = cur_q.x0[7:0];
				SLOT_X1_HI: beat.out_byte = cur_q.x1[15:8];
				SLOT_X1_LO: beat.out_byte = cur_q.x1[7:0];
				SLOT_RASET: begin
					beat.out_byte = CMD_RASET;
					beat.is_command = 1'b1;
				end
				SLOT_Y0_HI: beat.out_byte = cur_q.y0[15:8];
				SLOT_Y0_LO: beat.out_byte = cur_q.y0[7:0];
				SLOT_Y1_HI: beat.out_byte = cur_q.y1[15:8];
				SLOT_Y1_LO: beat.out_byte = cur_q.y1[7:0];
				SLOT_RAMWR: begin
					beat.out_byte = CMD_RAMWR;
					beat.is_command = 1'b1;
				end
				default: begin
				end
			endcase
		end else begin
			case (idx_q)
				SLOT_PIX_HI: beat.out_byte = cur_q.x0[15:8];
				SLOT_PIX_LO: begin
					beat.out_byte  = cur_q.x0[7:0];
					beat.frame_end = cur_q.frame_end;
				end
				default: begin
				end
			endcase
		end
	end

	// Current job payload and result queue entries
	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q <= job_head;
		end
		if (emit) begin
			oq_q[owr_q] <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (job_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 4'd1;
			end
			if (emit) begin
				owr_q <= ~owr_q;
			end
			if (pop_ok) begin
				ord_q <= ~ord_q;
			end
			ocnt_q <= ocnt_q + 2'(emit) - 2'(pop_ok);
		end
	end

	assign empty  = (ocnt_q == 2'd0);
	assign result = oq_q[ord_q];

endmodule

### sv/lcd_window_pixel_streamer_top.sv
// Top level of the LCD window pixel streamer.
//
// Turns region starts, full-frame starts and XRGB8888 pixels into the byte
// stream of a serial LCD controller, each byte tagged command or data.
// Input channel: push/full, one request per beat in item. Result channel:
// empty/pop, the oldest byte on result while empty is low. Registers
// panel_width and panel_height go through wr_en/wr_index/wr_data; the user
// must write them only while the block is idle; the block does not check.
// The first byte of an item passes through the job queue, the current-job
// register and the result queue. A start yields eleven bytes, a pixel two,
// one byte per cycle from the back-end sequencer while the result queue has
// room; the front takes a request in every cycle the job queue (four deep)
// has room.
// Reset clears the pixel count, both queues and the sequencer, and loads the
// panel size of 240 by 320. When pop stays low the two-entry result queue
// fills, the sequencer holds, the job queue fills and full rises; no beat is
// lost. Pixels with none left in the region, and the unused request code,
// are dropped at the front.
`include "lcd_window_pixel_streamer_top_defines.svh"

module lcd_window_pixel_streamer_top #(
	parameter int unsigned MAX_DIM = lwps_pkg::MAX_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  lwps_pkg::req_t                  item,
	output logic                            empty,
	input  logic                            pop,
	output lwps_pkg::res_t                  result,
	input  logic                            wr_en,
	input  logic [lwps_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [lwps_pkg::CFG_W-1:0]      wr_data
);
	import lwps_pkg::*;

	logic job_push, job_full, job_pop, job_empty;
	job_t job_in, job_head;

	// Decode, count pixels and build jobs
	lwps_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.job_full (job_full),
		.job_push (job_push),
		.job      (job_in)
	);

	// Decouple front from back so each side may stall alone
	lwps_job_q u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wr_job (job_in),
		.full   (job_full),
		.rd     (job_pop),
		.head   (job_head),
		.empty  (job_empty)
	);

	// Serialise each job into bytes
	lwps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job_head  (job_head),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	assign full = job_full;

	`LWPS_ASSERT_IMPLIES(a_job_push_room, job_push, !job_full, "job pushed into a full queue")
	`LWPS_ASSERT_IMPLIES(a_fe_is_last_data, (!empty && result.frame_end),
		(!result.is_command && result.run_last), "frame end on a non-final or command byte")
	`LWPS_ASSERT_NEXT(a_pop_after_job, (job_pop && job_empty), 1'b0, "job taken from empty queue")

endmodule
